@@ rtl/core/mpce_pkg.sv @@
// Package of shared types, reset constants and helper functions for the mouse event block.
package mpce_pkg;

  // Default number of buttons that are tracked.
  localparam int BUTTON_COUNT_DEF = 5;

  // Field widths fixed by the packet and event formats.
  localparam int DELTA_W  = 16;
  localparam int WHEEL_W  = 8;
  localparam int COORD_W  = 12;
  localparam int EDGE_W   = 13;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_KINDS = 4;

  // Reset rectangle.
  localparam logic [COORD_W-1:0] LEFT_RST   = 12'd0;
  localparam logic [COORD_W-1:0] TOP_RST    = 12'd0;
  localparam logic [EDGE_W-1:0]  RIGHT_RST  = 13'd640;
  localparam logic [EDGE_W-1:0]  BOTTOM_RST = 13'd480;

  // Largest allowed high edge: one past the last 12-bit coordinate.
  localparam logic [EDGE_W-1:0]  EDGE_MAX   = 13'd4096;

  // Cursor position after reset: centre of the reset rectangle.
  localparam logic [COORD_W-1:0] POS_X_RST =
    COORD_W'((int'(LEFT_RST) + int'(RIGHT_RST)) / 2);
  localparam logic [COORD_W-1:0] POS_Y_RST =
    COORD_W'((int'(TOP_RST) + int'(BOTTOM_RST)) / 2);

  // Event kinds, carried on the result channel's tuser.
  typedef enum logic [KIND_W-1:0] {
    EV_MOVE  = 2'd0,
    EV_DOWN  = 2'd1,
    EV_UP    = 2'd2,
    EV_WHEEL = 2'd3
  } event_kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_RIGHT  = 2'd2,
    CFG_BOTTOM = 2'd3
  } cfg_reg_t;

  // Forces a high edge into the range 1..4096.
  function automatic logic [EDGE_W-1:0] sat_high(input logic [EDGE_W-1:0] h);
    logic [EDGE_W-1:0] r;
    if (h == '0) begin
      r = EDGE_W'(1);
    end else if (h > EDGE_MAX) begin
      r = EDGE_MAX;
    end else begin
      r = h;
    end
    return r;
  endfunction

  // Centre of a span: halves the sum of the low edge and the saturated high edge.
  function automatic logic [COORD_W-1:0] centre(input logic [COORD_W-1:0] lo,
                                                input logic [EDGE_W-1:0]  hi);
    logic [EDGE_W:0] sum;
    sum = {2'b00, lo} + {1'b0, sat_high(hi)};
    return sum[COORD_W:1];
  endfunction

  // Adds a signed delta to a coordinate and clamps it: low edge first, then the
  // high edge, so an empty rectangle ends at high edge minus one.
  function automatic logic [COORD_W-1:0] clamp_axis(input logic [COORD_W-1:0] pos,
                                                    input logic [DELTA_W-1:0] d,
                                                    input logic [COORD_W-1:0] lo,
                                                    input logic [EDGE_W-1:0]  hi);
    logic signed [DELTA_W+1:0] v;
    logic signed [DELTA_W+1:0] lo_s;
    logic signed [DELTA_W+1:0] hi_s;
    v    = $signed({6'd0, pos}) + $signed({{2{d[DELTA_W-1]}}, d});
    lo_s = $signed({6'd0, lo});
    hi_s = $signed({5'd0, sat_high(hi)});
    if (v < lo_s) begin
      v = lo_s;
    end
    if (v >= hi_s) begin
      v = hi_s - 18'sd1;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

@@ rtl/core/mouse_packet_to_cursor_events.sv @@
// Top level of the mouse packet to cursor event converter.

// Each input transaction is one relative mouse packet. The block keeps the cursor
// position, clamped to the configured rectangle (left and top inclusive, right and
// bottom exclusive), and the button mask of the previous packet. A packet gives, in
// order, a move event if either delta is non-zero, a buttons-down event, a buttons-up
// event and a wheel event if the wheel delta is non-zero; packets that change nothing
// give no result. Every event carries the cursor position after its packet, and the
// final event of a packet has out_tlast set. Events leave one per cycle on the single
// result channel while out_tready is high, and a packet gives at most four of them. The
// next packet is taken in the same cycle as its predecessor's last event moves into the
// output register, so a packet with one event can follow in every cycle while the
// receiver keeps out_tready high. Any configuration write recentres the cursor at the
// middle of the rectangle; writes are expected only while the block is idle.
module mouse_packet_to_cursor_events #(
  parameter int BUTTON_COUNT = mpce_pkg::BUTTON_COUNT_DEF,
  localparam int IN_BITS  = 2 * mpce_pkg::DELTA_W + BUTTON_COUNT + mpce_pkg::WHEEL_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * mpce_pkg::COORD_W + BUTTON_COUNT + mpce_pkg::WHEEL_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,

  // Packet stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0 up: delta_x, delta_y, button_mask, wheel_delta, zero fill.
  input  logic [IN_W-1:0]                in_tdata,

  // Event stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0 up: cursor_x, cursor_y, changed_buttons, wheel_amount, zero fill.
  output logic [OUT_W-1:0]               out_tdata,
  // Fields from bit 0 up: event_kind.
  output logic [mpce_pkg::KIND_W-1:0]    out_tuser,
  // last_event.
  output logic                           out_tlast,

  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [mpce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpce_pkg::EDGE_W-1:0]    cfg_data
);

  localparam int DW = mpce_pkg::DELTA_W;
  localparam int CW = mpce_pkg::COORD_W;
  localparam int EW = mpce_pkg::EDGE_W;
  localparam int WW = mpce_pkg::WHEEL_W;
  localparam int NK = mpce_pkg::NUM_KINDS;

  // Unpacked packet fields.
  logic [DW-1:0]           in_dx;
  logic [DW-1:0]           in_dy;
  logic [BUTTON_COUNT-1:0] in_btn;
  logic [WW-1:0]           in_wheel;

  assign in_dx    = in_tdata[DW-1:0];
  assign in_dy    = in_tdata[2*DW-1:DW];
  assign in_btn   = in_tdata[2*DW+BUTTON_COUNT-1:2*DW];
  assign in_wheel = in_tdata[2*DW+BUTTON_COUNT+WW-1:2*DW+BUTTON_COUNT];

  // Rectangle registers.
  logic [CW-1:0] left_r,   left_nxt;
  logic [CW-1:0] top_r,    top_nxt;
  logic [EW-1:0] right_r,  right_nxt;
  logic [EW-1:0] bottom_r, bottom_nxt;

  // Cursor state and previous button mask.
  logic [CW-1:0]           pos_x_r, pos_x_nxt;
  logic [CW-1:0]           pos_y_r, pos_y_nxt;
  logic [BUTTON_COUNT-1:0] prev_btn_r, prev_btn_nxt;

  // Events of the current packet still to be sent, one bit per kind, with the
  // payloads they need. The position comes from the cursor state, which does not
  // change until the next packet is taken.
  logic [NK-1:0]           pend_r, pend_nxt;
  logic [BUTTON_COUNT-1:0] ev_down_r, ev_down_nxt;
  logic [BUTTON_COUNT-1:0] ev_up_r, ev_up_nxt;
  logic [WW-1:0]           ev_wheel_r, ev_wheel_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  mpce_pkg::event_kind_t   out_kind_r, out_kind_nxt;
  logic [CW-1:0]           out_x_r, out_x_nxt;
  logic [CW-1:0]           out_y_r, out_y_nxt;
  logic [BUTTON_COUNT-1:0] out_chg_r, out_chg_nxt;
  logic [WW-1:0]           out_wheel_r, out_wheel_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_accept;
  logic                    out_load;
  mpce_pkg::event_kind_t   sel_kind;
  logic [NK-1:0]           sel_bit;
  logic [NK-1:0]           pend_left;
  logic [BUTTON_COUNT-1:0] new_down;
  logic [BUTTON_COUNT-1:0] new_up;
  logic                    new_move;

  // The lowest pending kind goes out first, which gives the required order.
  always_comb begin
    if (pend_r[mpce_pkg::EV_MOVE]) begin
      sel_kind = mpce_pkg::EV_MOVE;
    end else if (pend_r[mpce_pkg::EV_DOWN]) begin
      sel_kind = mpce_pkg::EV_DOWN;
    end else if (pend_r[mpce_pkg::EV_UP]) begin
      sel_kind = mpce_pkg::EV_UP;
    end else begin
      sel_kind = mpce_pkg::EV_WHEEL;
    end
  end

  assign sel_bit   = NK'(1) << sel_kind;
  assign out_load  = (pend_r != '0) && (!out_valid_r || out_tready);
  assign pend_left = out_load ? (pend_r & ~sel_bit) : pend_r;

  // A new packet is taken once nothing of the previous one is left waiting behind
  // the output register.
  assign in_tready = (pend_left == '0);
  assign in_accept = in_tvalid && in_tready;

  assign new_down = in_btn & ~prev_btn_r;
  assign new_up   = ~in_btn & prev_btn_r;
  assign new_move = (in_dx != '0) || (in_dy != '0);

  // Configuration and cursor state.
  always_comb begin
    left_nxt     = left_r;
    top_nxt      = top_r;
    right_nxt    = right_r;
    bottom_nxt   = bottom_r;
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    prev_btn_nxt = prev_btn_r;

    if (cfg_we) begin
      case (mpce_pkg::cfg_reg_t'(cfg_index))
        mpce_pkg::CFG_LEFT:   left_nxt   = cfg_data[CW-1:0];
        mpce_pkg::CFG_TOP:    top_nxt    = cfg_data[CW-1:0];
        mpce_pkg::CFG_RIGHT:  right_nxt  = cfg_data;
        mpce_pkg::CFG_BOTTOM: bottom_nxt = cfg_data;
        default: ;
      endcase
      pos_x_nxt = mpce_pkg::centre(left_nxt, right_nxt);
      pos_y_nxt = mpce_pkg::centre(top_nxt, bottom_nxt);
    end else if (in_accept) begin
      if (new_move) begin
        pos_x_nxt = mpce_pkg::clamp_axis(pos_x_r, in_dx, left_r, right_r);
        pos_y_nxt = mpce_pkg::clamp_axis(pos_y_r, in_dy, top_r, bottom_r);
      end
      prev_btn_nxt = in_btn;
    end
  end

  // Pending events.
  always_comb begin
    pend_nxt     = pend_left;
    ev_down_nxt  = ev_down_r;
    ev_up_nxt    = ev_up_r;
    ev_wheel_nxt = ev_wheel_r;
    if (in_accept) begin
      pend_nxt[mpce_pkg::EV_MOVE]  = new_move;
      pend_nxt[mpce_pkg::EV_DOWN]  = (new_down != '0);
      pend_nxt[mpce_pkg::EV_UP]    = (new_up != '0);
      pend_nxt[mpce_pkg::EV_WHEEL] = (in_wheel != '0);
      ev_down_nxt  = new_down;
      ev_up_nxt    = new_up;
      ev_wheel_nxt = in_wheel;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_chg_nxt   = out_chg_r;
    out_wheel_nxt = out_wheel_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = sel_kind;
      out_x_nxt     = pos_x_r;
      out_y_nxt     = pos_y_r;
      out_last_nxt  = ((pend_r & ~sel_bit) == '0);
      out_chg_nxt   = '0;
      out_wheel_nxt = '0;
      case (sel_kind)
        mpce_pkg::EV_DOWN:  out_chg_nxt   = ev_down_r;
        mpce_pkg::EV_UP:    out_chg_nxt   = ev_up_r;
        mpce_pkg::EV_WHEEL: out_wheel_nxt = ev_wheel_r;
        default: ;
      endcase
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= mpce_pkg::LEFT_RST;
      top_r       <= mpce_pkg::TOP_RST;
      right_r     <= mpce_pkg::RIGHT_RST;
      bottom_r    <= mpce_pkg::BOTTOM_RST;
      pos_x_r     <= mpce_pkg::POS_X_RST;
      pos_y_r     <= mpce_pkg::POS_Y_RST;
      prev_btn_r  <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      top_r       <= top_nxt;
      right_r     <= right_nxt;
      bottom_r    <= bottom_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      prev_btn_r  <= prev_btn_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    ev_down_r   <= ev_down_nxt;
    ev_up_r     <= ev_up_nxt;
    ev_wheel_r  <= ev_wheel_nxt;
    out_kind_r  <= out_kind_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_chg_r   <= out_chg_nxt;
    out_wheel_r <= out_wheel_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_wheel_r, out_chg_r, out_y_r, out_x_r});

endmodule

@@ tb/mpce_tb_pkg.sv @@
// Scoreboard class that predicts and checks the cursor events of the mouse event block.
package mpce_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import mpce_pkg::*;

  typedef struct {
    event_kind_t kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [4:0]  chg;
    logic [7:0]  wheel;
    logic        last;
  } cursor_event_t;

  class cursor_scoreboard;
    logic [11:0]   left_e;
    logic [11:0]   top_e;
    logic [12:0]   right_e;
    logic [12:0]   bottom_e;
    logic [11:0]   cur_x;
    logic [11:0]   cur_y;
    logic [4:0]    held_buttons;
    cursor_event_t pending_events[$];
    int            mismatches;

    function new();
      left_e       = 12'd0;
      top_e        = 12'd0;
      right_e      = 13'd640;
      bottom_e     = 13'd480;
      held_buttons = 5'd0;
      mismatches   = 0;
      recentre();
    endfunction

    // High edges are forced into 1..4096 wherever they are used.
    function int usable_high(logic [12:0] h);
      if (h == 13'd0) begin
        return 1;
      end
      if (h > 13'd4096) begin
        return 4096;
      end
      return int'(h);
    endfunction

    function void recentre();
      cur_x = 12'((int'(left_e) + usable_high(right_e)) / 2);
      cur_y = 12'((int'(top_e) + usable_high(bottom_e)) / 2);
    endfunction

    // The high edge wins, so an empty rectangle parks the cursor at high edge minus one.
    function int clamp_coord(int v, int lo, int hi);
      if (v < lo) begin
        v = lo;
      end
      if (v >= hi) begin
        v = hi - 1;
      end
      return v;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [12:0] value);
      case (idx)
        CFG_LEFT:   left_e   = value[11:0];
        CFG_TOP:    top_e    = value[11:0];
        CFG_RIGHT:  right_e  = value;
        CFG_BOTTOM: bottom_e = value;
        default: ;
      endcase
      recentre();
    endfunction

    function cursor_event_t make_event(event_kind_t kind, logic [4:0] chg, logic [7:0] wheel);
      cursor_event_t ev;
      ev.kind  = kind;
      ev.x     = cur_x;
      ev.y     = cur_y;
      ev.chg   = chg;
      ev.wheel = wheel;
      ev.last  = 1'b0;
      return ev;
    endfunction

    function void note_packet(logic signed [15:0] dx, logic signed [15:0] dy,
                              logic [4:0] buttons, logic signed [7:0] wheel);
      cursor_event_t batch[$];
      logic [4:0]    pressed;
      logic [4:0]    released;
      pressed  = buttons & ~held_buttons;
      released = ~buttons & held_buttons;
      if (dx != 16'sd0 || dy != 16'sd0) begin
        cur_x = 12'(clamp_coord(int'(cur_x) + int'(dx), int'(left_e), usable_high(right_e)));
        cur_y = 12'(clamp_coord(int'(cur_y) + int'(dy), int'(top_e), usable_high(bottom_e)));
        batch.push_back(make_event(EV_MOVE, 5'd0, 8'd0));
      end
      if (pressed != 5'd0) begin
        batch.push_back(make_event(EV_DOWN, pressed, 8'd0));
      end
      if (released != 5'd0) begin
        batch.push_back(make_event(EV_UP, released, 8'd0));
      end
      held_buttons = buttons;
      if (wheel != 8'sd0) begin
        batch.push_back(make_event(EV_WHEEL, 5'd0, wheel));
      end
      if (batch.size() > 0) begin
        batch[batch.size() - 1].last = 1'b1;
      end
      foreach (batch[i]) begin
        pending_events.push_back(batch[i]);
      end
    endfunction

    function void check_field(string name, logic [11:0] expv, logic [11:0] actv);
      if (actv !== expv) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
        mismatches++;
      end
    endfunction

    function void check_event(logic [1:0] kind, logic [11:0] x, logic [11:0] y,
                              logic [4:0] chg, logic [7:0] wheel, logic last);
      cursor_event_t ev;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d x %0d y %0d",
                 $time, kind, x, y);
        mismatches++;
        return;
      end
      ev = pending_events.pop_front();
      check_field("event_kind", 12'(ev.kind), 12'(kind));
      check_field("cursor_x", ev.x, x);
      check_field("cursor_y", ev.y, y);
      check_field("changed_buttons", 12'(ev.chg), 12'(chg));
      check_field("wheel_amount", 12'(ev.wheel), 12'(wheel));
      check_field("last_event", 12'(ev.last), 12'(last));
    endfunction

    function int outstanding();
      return pending_events.size();
    endfunction
  endclass

endpackage

@@ tb/mouse_packet_to_cursor_events_tb.sv @@
// Testbench top level for the mouse packet to cursor event converter.
module mouse_packet_to_cursor_events_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpce_pkg::*;
  import mpce_tb_pkg::*;

  localparam int IN_W        = 48;
  localparam int OUT_W       = 40;
  // Cycles without any transaction on either channel before the run is abandoned. The
  // longest honest quiet spell is the long receiver hold plus a settling pause.
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 150;
  localparam int PHASE_ITEMS = 14;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;
  logic             cfg_we     = 1'b0;
  logic [1:0]       cfg_index  = CFG_LEFT;
  logic [12:0]      cfg_data   = '0;

  cursor_scoreboard events_sb;
  // When calm is set neither side inserts random gaps or stalls; a requested long hold still applies.
  bit               calm       = 1'b0;
  // Asks the receiver to hold off for a long stretch.
  bit               hold_req   = 1'b0;
  int               idle_cycles = 0;
  logic [4:0]       last_mask  = 5'd0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  mouse_packet_to_cursor_events i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  // The receiver decides out_tready once per falling edge. A long hold, when asked
  // for, is counted down here so that the sender keeps offering packets meanwhile and
  // the block has to back up into its input.
  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Both channels are observed at the rising edge. Events leaving are checked before a
  // packet accepted in the same cycle is predicted, since they belong to older packets.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        events_sb.check_event(out_tuser, out_tdata[11:0], out_tdata[23:12],
                              out_tdata[28:24], out_tdata[36:29], out_tlast);
      end
      if (in_tvalid && in_tready) begin
        events_sb.note_packet(in_tdata[15:0], in_tdata[31:16], in_tdata[36:32],
                              in_tdata[44:37]);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offers one packet, after a random gap, and returns at the falling edge following its
  // transaction. With no gap in_tvalid simply stays high into the next packet.
  task automatic send_packet(input logic signed [15:0] dx, input logic signed [15:0] dy,
                             input logic [4:0] buttons, input logic signed [7:0] wheel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, wheel, buttons, dy, dx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    last_mask = buttons;
  endtask

  // Waits until every predicted event has left, then goes on waiting in case the last
  // packet caused no event and is still being worked on.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (events_sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Each write recentres the cursor; cfg_we drops between consecutive writes.
  task automatic write_reg(input cfg_reg_t idx, input logic [12:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    events_sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_rect(input logic [12:0] l, input logic [12:0] t,
                          input logic [12:0] r, input logic [12:0] b);
    settle();
    write_reg(CFG_LEFT, l);
    write_reg(CFG_TOP, t);
    write_reg(CFG_RIGHT, r);
    write_reg(CFG_BOTTOM, b);
  endtask

  // Most rectangles are sensible; some are random over the whole register range, which
  // brings in empty, inverted and saturated ones, and some are a single pixel wide.
  task automatic random_rect();
    logic [12:0] l;
    logic [12:0] t;
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      l = 13'($urandom_range(0, 2000));
      t = 13'($urandom_range(0, 2000));
      set_rect(l, t, l + 13'($urandom_range(1, 2096)), t + 13'($urandom_range(1, 2096)));
    end else if (mode < 9) begin
      set_rect(13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
    end else begin
      l = 13'($urandom_range(0, 4095));
      t = 13'($urandom_range(0, 4095));
      set_rect(l, t, l + 13'd1, t + 13'd1);
    end
  endtask

  // Deltas are mostly small so that the cursor wanders inside the rectangle, with some
  // zero packets, some full-range ones and some at the extremes. Buttons usually keep
  // the previous mask or change one button of it, so presses and releases stay realistic.
  task automatic random_packet();
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [4:0]         buttons;
    logic signed [7:0]  wheel;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      dx = 16'sd0;
      dy = 16'sd0;
    end else if (r < 75) begin
      dx = 16'(int'($urandom_range(0, 40)) - 20);
      dy = 16'(int'($urandom_range(0, 40)) - 20);
    end else if (r < 90) begin
      dx = 16'($urandom);
      dy = 16'($urandom);
    end else begin
      dx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      dy = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      buttons = last_mask;
    end else if (r < 80) begin
      buttons = last_mask ^ (5'd1 << $urandom_range(0, 4));
    end else begin
      buttons = 5'($urandom);
    end
    wheel = $urandom_range(0, 1) ? 8'sd0 : 8'($urandom);
    send_packet(dx, dy, buttons, wheel);
  endtask

  initial begin : stimulus
    events_sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed packets in the reset rectangle, cursor starting at its centre.
    send_packet(16'sd0, 16'sd0, 5'b00000, 8'sd0);           // changes nothing
    send_packet(16'sd5, -16'sd3, 5'b00000, 8'sd0);          // plain move
    send_packet(16'sd0, 16'sd0, 5'b11111, 8'sd0);           // every button pressed
    send_packet(16'sd0, 16'sd0, 5'b00000, 8'sd0);           // every button released
    send_packet(16'sd0, 16'sd0, 5'b00000, 8'sd127);         // wheel at its maximum
    send_packet(16'sd0, 16'sd0, 5'b00000, -8'sd128);        // wheel at its minimum
    send_packet(16'sh7fff, 16'sh7fff, 5'b10101, 8'sd1);     // move, press, wheel
    send_packet(16'sh8000, 16'sh8000, 5'b01010, -8'sd1);    // all four events
    send_packet(16'sd0, 16'sd7, 5'b01010, 8'sd0);           // move on one axis only
    send_packet(16'sd1, 16'sd0, 5'b01010, 8'sd0);
    send_packet(16'sd0, 16'sd0, 5'b01010, 8'sd0);           // same buttons, nothing
    send_packet(-16'sd1, -16'sd1, 5'b00001, 8'sd0);         // press and release together

    // Empty rectangle on x and a zero bottom edge: both axes end at high edge minus one.
    set_rect(13'd100, 13'd50, 13'd100, 13'd0);
    send_packet(16'sd10, 16'sd10, 5'b00001, 8'sd0);
    send_packet(-16'sd300, 16'sd0, 5'b00000, 8'sd3);

    // Out of range high edges saturate; the top bit of a low edge write is dropped.
    set_rect(13'h1fff, 13'h1000, 13'h1fff, 13'd5000);
    send_packet(16'sh8000, 16'sh7fff, 5'b10000, 8'sd0);
    send_packet(16'sh7fff, 16'sh8000, 5'b01000, 8'sd0);

    // Whole coordinate space.
    set_rect(13'd0, 13'd0, 13'd4096, 13'd4096);
    send_packet(16'sh7fff, 16'sh7fff, 5'b00000, 8'sd0);
    send_packet(16'sh8000, 16'sh8000, 5'b11111, -8'sd128);
    send_packet(16'sd4095, 16'sd4095, 5'b00000, 8'sd127);

    // Random phases under fresh rectangles. One phase runs with no idling at all, and the
    // next starts with a long receiver hold while packets keep coming.
    for (int phase = 0; phase < 6; phase++) begin
      random_rect();
      calm = (phase == 2 || phase == 3);
      if (phase == 3) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) random_packet();
    end

    calm = 1'b0;
    settle();
    repeat (20) @(negedge clk);
    if (events_sb.mismatches == 0 && events_sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
